### rtl/scsa_pkg.sv
// Shared types, constants and size-class tables for the slab allocator core.
`timescale 1ns / 1ps
`default_nettype none
package scsa_pkg;

   localparam int PAGE_BYTES   = 65536;
   localparam int HEADER_BYTES = 32;
   localparam int CLASS_COUNT  = 32;
   localparam int PAGE_COUNT   = 8;
   localparam int PAGE_W       = 3;
   localparam int HEAD_W       = 4;
   localparam int CLS_W        = 5;
   localparam int SLOT_W       = 14;
   localparam int TOP_W        = 15;
   localparam int OFF_W        = 16;
   localparam int ADDR_W       = 19;
   localparam int GRAN_W       = 16;
   localparam int PROD_W       = SLOT_W + GRAN_W;
   localparam int MEM_AW       = PAGE_W + SLOT_W;

   localparam logic [HEAD_W-1:0] NO_PAGE = '1;
   localparam logic [TOP_W-1:0]  NO_SLOT = '1;
   localparam logic [31:0]       MAX_REQ = 32'(PAGE_BYTES / 2);

   typedef enum logic [1:0] {
      RS_OK        = 2'd0,
      RS_NO_PAGE   = 2'd1,
      RS_TOO_LARGE = 2'd2,
      RS_BAD_FREE  = 2'd3
   } rsp_status_type;

   // Bytes per slot of each class.
   localparam logic [GRAN_W-1:0] CLASS_GRAN [CLASS_COUNT] = '{
      16'd4, 16'd8, 16'd12, 16'd16, 16'd20, 16'd24, 16'd32, 16'd40,
      16'd52, 16'd68, 16'd88, 16'd116, 16'd152, 16'd200, 16'd264, 16'd352,
      16'd468, 16'd624, 16'd832, 16'd1108, 16'd1476, 16'd1968, 16'd2624, 16'd3496,
      16'd4660, 16'd6212, 16'd8280, 16'd11040, 16'd14720, 16'd19624, 16'd26164,
      16'd34884};

   // Slots per page of each class.
   localparam logic [SLOT_W-1:0] CLASS_SLOTS [CLASS_COUNT] = '{
      14'd16376, 14'd8188, 14'd5458, 14'd4094, 14'd3275, 14'd2729, 14'd2047, 14'd1637,
      14'd1259, 14'd963, 14'd744, 14'd564, 14'd430, 14'd327, 14'd248, 14'd186,
      14'd139, 14'd104, 14'd78, 14'd59, 14'd44, 14'd33, 14'd24, 14'd18,
      14'd14, 14'd10, 14'd7, 14'd5, 14'd4, 14'd3, 14'd2, 14'd1};

   typedef enum logic [3:0] {
      ST_IDLE, ST_A_HEAD, ST_A_SLOT, ST_A_FIN, ST_A_ADDR, ST_F_CHK, ST_F_DIV,
      ST_F_SLOT, ST_SW_HEAD, ST_SW_NODE, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LATCH, OP_A_HEAD, OP_A_SLOT, OP_A_FIN, OP_A_ADDR, OP_F_CHK,
      OP_F_DIV, OP_F_SLOT, OP_SW_HEAD, OP_SW_NODE, OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic sweep_need;
      logic div_last;
      logic walk_end;
      logic class_last;
      logic out_free;
   } stat_type;

   // Smallest class whose slot holds need bytes.
   function automatic logic [CLS_W-1:0] class_of(input logic [16:0] need);
      logic [CLS_W-1:0] cls;
      cls = '0;
      for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
         if (17'(CLASS_GRAN[i]) >= need) begin
            cls = CLS_W'(i);
         end
      end
      return cls;
   endfunction

endpackage
`default_nettype wire

### rtl/size_class_slab_allocator_core.sv
// Top level of the size-class slab allocator core.
// Allocate runs head, slot, finish and address steps; free runs check, divider and
//   slot steps, plus a list sweep when a free empties a page; an item that fails its
//   first check (too large, no page, bad page or header) goes straight to the result.
// One word at a time: a new word is accepted only once the last result is emitted.
// Reset: synchronous, clears class heads and page map; slot memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module size_class_slab_allocator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,  // request_bytes[31:0], block_address[50:32]
   input  wire logic        req_tuser,  // kind: 0 allocate, 1 free
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata   // granted_address[18:0], status[20:19]
);
   import scsa_pkg::*;

   cmd_type     cmd;
   stat_type    st;
   logic [18:0] rsp_addr;
   logic [1:0]  rsp_status;

   // Sequencer: accept one word, step it through the datapath, hold until taken.
   scsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   // Datapath: class tables, page records, slot link memory and result register.
   scsa_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .in_kind    (req_tuser),
      .in_bytes   (req_tdata[31:0]),
      .in_addr    (req_tdata[50:32]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_addr   (rsp_addr),
      .rsp_status (rsp_status)
   );

   // Pack the result word; pad bits stay zero.
   assign rsp_tdata = {3'b000, rsp_status, rsp_addr};

endmodule
`default_nettype wire

### rtl/scsa_ctrl.sv
// Sequencer that steps the datapath through allocate, free and list sweep.
`timescale 1ns / 1ps
`default_nettype none
module scsa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_kind,
   output logic                   req_tready,
   input  wire scsa_pkg::stat_type st,
   output scsa_pkg::cmd_type      cmd
);
   import scsa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LATCH;
               state_in = req_kind ? ST_F_CHK : ST_A_HEAD;
            end
         end
         ST_A_HEAD: begin
            cmd.op   = OP_A_HEAD;
            state_in = st.err ? ST_DONE : ST_A_SLOT;
         end
         ST_A_SLOT: begin
            cmd.op   = OP_A_SLOT;
            state_in = ST_A_FIN;
         end
         ST_A_FIN: begin
            cmd.op   = OP_A_FIN;
            state_in = ST_A_ADDR;
         end
         ST_A_ADDR: begin
            cmd.op   = OP_A_ADDR;
            state_in = ST_DONE;
         end
         ST_F_CHK: begin
            cmd.op   = OP_F_CHK;
            state_in = st.err ? ST_DONE : ST_F_DIV;
         end
         ST_F_DIV: begin
            cmd.op = OP_F_DIV;
            if (st.div_last) begin
               state_in = ST_F_SLOT;
            end
         end
         ST_F_SLOT: begin
            cmd.op = OP_F_SLOT;
            priority if (st.err) begin
               state_in = ST_DONE;
            end else if (st.sweep_need) begin
               state_in = ST_SW_HEAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SW_HEAD: begin
            cmd.op   = OP_SW_HEAD;
            state_in = ST_SW_NODE;
         end
         ST_SW_NODE: begin
            cmd.op = OP_SW_NODE;
            if (st.walk_end) begin
               state_in = st.class_last ? ST_DONE : ST_SW_HEAD;
            end
         end
         ST_DONE: begin
            if (st.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### rtl/scsa_dpath.sv
// Allocator state, slot link memory, divider, multiplier and result register.
`timescale 1ns / 1ps
`default_nettype none
module scsa_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire scsa_pkg::cmd_type cmd,
   output scsa_pkg::stat_type     st,
   input  wire logic              in_kind,
   input  wire logic [31:0]       in_bytes,
   input  wire logic [18:0]       in_addr,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [18:0]            rsp_addr,
   output logic [1:0]             rsp_status
);
   import scsa_pkg::*;

   // control state
   logic [HEAD_W-1:0]     head_ff [CLASS_COUNT];
   logic [PAGE_COUNT-1:0] busy_ff;
   logic                  rsp_valid_ff;
   // per-page records
   logic [HEAD_W-1:0]     link_ff  [PAGE_COUNT];
   logic [CLS_W-1:0]      pcls_ff  [PAGE_COUNT];
   logic [SLOT_W-1:0]     used_ff  [PAGE_COUNT];
   logic [SLOT_W-1:0]     fresh_ff [PAGE_COUNT];
   logic [TOP_W-1:0]      top_ff   [PAGE_COUNT];
   // slot link memory
   logic [TOP_W-1:0]      slot_mem [2**MEM_AW];
   logic [TOP_W-1:0]      mem_q_ff;
   // item registers
   logic                  kind_ff, big_ff, from_stack_ff;
   logic [CLS_W-1:0]      cls_ff, sw_c_ff;
   logic [PAGE_W-1:0]     page_ff;
   logic [OFF_W-1:0]      off_ff, div_q_ff, div_r_ff;
   logic [3:0]            div_n_ff, walk_n_ff;
   logic [HEAD_W-1:0]     walk_p_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [ADDR_W-1:0]     res_addr_ff, out_addr_ff;
   rsp_status_type        res_status_ff, out_status_ff;

   logic                  sweeping, mem_we, walk_ok, pg_full, new_full;
   logic [CLS_W-1:0]      hidx;
   logic [PAGE_W-1:0]     pidx, free_pg;
   logic                  free_any;
   logic [HEAD_W-1:0]     head_rd;
   logic [TOP_W-1:0]      top_rd, new_top;
   logic [SLOT_W-1:0]     lim;
   logic [GRAN_W-1:0]     gran;
   logic [16:0]           need, trial;
   logic [MEM_AW-1:0]     mem_wa, mem_ra;

   assign sweeping = (cmd.op == OP_SW_HEAD) || (cmd.op == OP_SW_NODE);
   assign hidx     = sweeping ? sw_c_ff : cls_ff;
   assign pidx     = (cmd.op == OP_SW_NODE) ? walk_p_ff[PAGE_W-1:0] : page_ff;
   assign head_rd  = head_ff[hidx];
   assign top_rd   = top_ff[pidx];
   assign lim      = CLASS_SLOTS[cls_ff];
   assign gran     = CLASS_GRAN[cls_ff];
   assign pg_full  = (top_rd == NO_SLOT) && (fresh_ff[pidx] >= lim);
   assign new_top  = from_stack_ff ? mem_q_ff : top_rd;
   assign new_full = (new_top == NO_SLOT) && (fresh_ff[pidx] >= lim);
   assign walk_ok  = (walk_p_ff < HEAD_W'(PAGE_COUNT)) && (walk_n_ff < 4'(PAGE_COUNT));
   assign trial    = {div_r_ff, div_q_ff[OFF_W-1]} - {1'b0, gran};
   assign need     = (in_bytes[16:0] == '0) ? 17'd4 : ((in_bytes[16:0] + 17'd3) & ~17'd3);
   assign mem_ra   = {page_ff, top_rd[SLOT_W-1:0]};
   assign mem_wa   = {page_ff, div_q_ff[SLOT_W-1:0]};

   always_comb begin
      free_any = 1'b0;
      free_pg  = '0;
      for (int i = PAGE_COUNT - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_any = 1'b1;
            free_pg  = PAGE_W'(i);
         end
      end
   end

   // status back to the sequencer
   always_comb begin
      st.err = 1'b0;
      unique case (cmd.op)
         OP_A_HEAD: st.err = big_ff || ((head_rd >= HEAD_W'(PAGE_COUNT)) && !free_any);
         OP_F_CHK:  st.err = !busy_ff[page_ff] || (off_ff < OFF_W'(HEADER_BYTES));
         OP_F_SLOT: st.err = (div_r_ff != '0) || (div_q_ff >= OFF_W'(fresh_ff[pidx]))
                             || (div_q_ff >= OFF_W'(lim));
         default:   st.err = 1'b0;
      endcase
      st.sweep_need = (used_ff[pidx] <= SLOT_W'(1));
      st.div_last   = (div_n_ff == 4'd15);
      st.walk_end   = !walk_ok;
      st.class_last = (sw_c_ff == CLS_W'(CLASS_COUNT - 1));
      st.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign mem_we = (cmd.op == OP_F_SLOT) && !st.err;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= top_rd;
      end
      mem_q_ff <= slot_mem[mem_ra];
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CLASS_COUNT; i++) begin
            head_ff[i] <= NO_PAGE;
         end
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd.op)
            OP_A_HEAD: begin
               if (!st.err && (head_rd >= HEAD_W'(PAGE_COUNT))) begin
                  busy_ff[free_pg] <= 1'b1;
                  head_ff[hidx]    <= HEAD_W'(free_pg);
               end
            end
            OP_A_FIN: begin
               if (new_full) begin
                  head_ff[hidx] <= link_ff[pidx];
               end
            end
            OP_F_SLOT: begin
               if (!st.err && pg_full) begin
                  head_ff[hidx] <= HEAD_W'(page_ff);
               end
            end
            OP_SW_HEAD: head_ff[hidx] <= NO_PAGE;
            OP_SW_NODE: begin
               if (walk_ok) begin
                  if (used_ff[pidx] == '0) begin
                     busy_ff[pidx] <= 1'b0;
                  end else begin
                     head_ff[hidx] <= HEAD_W'(pidx);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // payload and page records
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LATCH: begin
            kind_ff       <= in_kind;
            big_ff        <= in_bytes > MAX_REQ;
            cls_ff        <= class_of(need);
            page_ff       <= in_addr[ADDR_W-1:OFF_W];
            off_ff        <= in_addr[OFF_W-1:0];
            res_addr_ff   <= '0;
            res_status_ff <= RS_OK;
         end
         OP_A_HEAD: begin
            priority if (big_ff) begin
               res_status_ff <= RS_TOO_LARGE;
            end else if (head_rd < HEAD_W'(PAGE_COUNT)) begin
               page_ff <= head_rd[PAGE_W-1:0];
            end else if (!free_any) begin
               res_status_ff <= RS_NO_PAGE;
            end else begin
               page_ff           <= free_pg;
               pcls_ff[free_pg]  <= cls_ff;
               used_ff[free_pg]  <= '0;
               fresh_ff[free_pg] <= '0;
               top_ff[free_pg]   <= NO_SLOT;
               link_ff[free_pg]  <= NO_PAGE;
            end
         end
         OP_A_SLOT: begin
            if ((top_rd != NO_SLOT) && !top_rd[TOP_W-1]) begin
               slot_ff       <= top_rd[SLOT_W-1:0];
               from_stack_ff <= 1'b1;
            end else begin
               slot_ff        <= fresh_ff[pidx];
               fresh_ff[pidx] <= fresh_ff[pidx] + SLOT_W'(1);
               top_ff[pidx]   <= NO_SLOT;
               from_stack_ff  <= 1'b0;
            end
            used_ff[pidx] <= used_ff[pidx] + SLOT_W'(1);
         end
         OP_A_FIN: begin
            if (from_stack_ff) begin
               top_ff[pidx] <= mem_q_ff;
            end
            prod_ff <= PROD_W'(slot_ff) * PROD_W'(gran);
         end
         OP_A_ADDR: begin
            res_addr_ff <= ADDR_W'({page_ff, OFF_W'(0)}) + ADDR_W'(HEADER_BYTES)
                           + prod_ff[ADDR_W-1:0];
         end
         OP_F_CHK: begin
            if (st.err) begin
               res_status_ff <= RS_BAD_FREE;
            end else begin
               cls_ff   <= pcls_ff[pidx];
               div_q_ff <= off_ff - OFF_W'(HEADER_BYTES);
               div_r_ff <= '0;
               div_n_ff <= '0;
            end
         end
         OP_F_DIV: begin
            // one quotient bit a cycle
            if (!trial[16]) begin
               div_r_ff <= trial[OFF_W-1:0];
            end else begin
               div_r_ff <= {div_r_ff[OFF_W-2:0], div_q_ff[OFF_W-1]};
            end
            div_q_ff <= {div_q_ff[OFF_W-2:0], !trial[16]};
            div_n_ff <= div_n_ff + 4'd1;
         end
         OP_F_SLOT: begin
            sw_c_ff <= '0;
            if (st.err) begin
               res_status_ff <= RS_BAD_FREE;
            end else begin
               if (pg_full) begin
                  link_ff[pidx] <= head_rd;
               end
               top_ff[pidx] <= {1'b0, div_q_ff[SLOT_W-1:0]};
               if (used_ff[pidx] != '0) begin
                  used_ff[pidx] <= used_ff[pidx] - SLOT_W'(1);
               end
            end
         end
         OP_SW_HEAD: begin
            walk_p_ff <= head_rd;
            walk_n_ff <= '0;
         end
         OP_SW_NODE: begin
            if (walk_ok) begin
               if (used_ff[pidx] != '0) begin
                  link_ff[pidx] <= head_rd;
               end
               walk_p_ff <= link_ff[pidx];
               walk_n_ff <= walk_n_ff + 4'd1;
            end else begin
               sw_c_ff <= sw_c_ff + CLS_W'(1);
            end
         end
         OP_EMIT: begin
            out_addr_ff   <= res_addr_ff;
            out_status_ff <= res_status_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_addr   = out_addr_ff;
   assign rsp_status = out_status_ff;

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |=> rsp_valid_ff)
      else $error("result not raised after emit");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_SW_NODE |-> walk_n_ff <= 4'(PAGE_COUNT))
      else $error("list walk ran past page count");
   a_grant_hdr: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT && !kind_ff && res_status_ff == RS_OK)
      |-> res_addr_ff[OFF_W-1:0] >= OFF_W'(HEADER_BYTES))
      else $error("granted block overlaps page header");

endmodule
`default_nettype wire

### tb/sv/size_class_slab_allocator_core_tb.sv
// Self-checking testbench for the size-class slab allocator core.
`timescale 1ns / 1ps
`default_nettype none
module size_class_slab_allocator_core_tb;
   import scsa_pkg::*;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;
   localparam int   SLOT_SPAN  = 16384;   // slot_link entries per page
   localparam int   DRAIN_CYC  = 400;     // covers the longest list sweep

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      rsp_status_type    status;
   } grant_word_type;

   // Clock, reset and ports; every input known from time zero.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;   // request_bytes[31:0], block_address[50:32]
   logic        req_tuser  = 1'b0; // kind: 0 allocate, 1 free
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // granted_address[18:0], status[20:19]

   size_class_slab_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Shadow allocator state, mirrored word by word from the accepted inputs.
   int unsigned       class_bytes [CLASS_COUNT];
   int unsigned       class_cap   [CLASS_COUNT];
   logic [HEAD_W-1:0] shadow_head [CLASS_COUNT];
   logic [HEAD_W-1:0] shadow_link [PAGE_COUNT];
   logic [CLS_W-1:0]  shadow_cls  [PAGE_COUNT];
   int unsigned       shadow_used [PAGE_COUNT];
   int unsigned       shadow_fresh[PAGE_COUNT];
   logic [TOP_W-1:0]  shadow_top  [PAGE_COUNT];
   logic [TOP_W-1:0]  shadow_chain[int];
   logic [PAGE_COUNT-1:0] shadow_busy;

   grant_word_type expected_grants[$];
   logic [ADDR_W-1:0] live_blocks[$];
   logic [ADDR_W-1:0] freed_blocks[$];
   int  mismatch_count = 0;
   bit  gaps_off = 1'b0;
   int  rsp_hold_cycles = 0;

   // Build the geometric class table on our own.
   initial begin
      int unsigned cur, nx;
      cur = 4;
      for (int c = 0; c < CLASS_COUNT; c++) begin
         class_bytes[c] = cur;
         class_cap[c]   = (PAGE_BYTES - HEADER_BYTES) / cur;
         if (class_cap[c] > SLOT_SPAN) class_cap[c] = SLOT_SPAN;
         nx = (cur * 4) / 3;
         nx = nx - nx % 4;
         if (nx == cur) nx = nx + 4;
         cur = nx;
      end
      for (int c = 0; c < CLASS_COUNT; c++) shadow_head[c] = NO_PAGE;
      shadow_busy = '0;
   end

   function automatic bit page_exhausted(int p, int unsigned cap);
      return shadow_top[p] == NO_SLOT && shadow_fresh[p] >= cap;
   endfunction

   // Drop emptied pages and rebuild every class list in reversed order.
   function automatic void sweep_classes();
      int p, n, nx;
      for (int c = 0; c < CLASS_COUNT; c++) begin
         p = int'(shadow_head[c]);
         n = 0;
         shadow_head[c] = NO_PAGE;
         while (p < PAGE_COUNT && n < PAGE_COUNT) begin
            nx = int'(shadow_link[p]);
            if (shadow_used[p] == 0) begin
               shadow_busy[p] = 1'b0;
            end else begin
               shadow_link[p] = shadow_head[c];
               shadow_head[c] = HEAD_W'(p);
            end
            p = nx;
            n++;
         end
      end
   endfunction

   function automatic grant_word_type grant_for_alloc(logic [31:0] bytes);
      grant_word_type g;
      longint unsigned need;
      int c, p;
      int unsigned cap, slot;
      g = '{addr: '0, status: RS_TOO_LARGE};
      if (bytes > PAGE_BYTES / 2) return g;
      need = (bytes == 0) ? 4 : ((longint'(bytes) - 1) / 4 + 1) * 4;
      for (c = 0; c < CLASS_COUNT; c++) if (class_bytes[c] >= need) break;
      if (c >= CLASS_COUNT) return g;
      cap = class_cap[c];
      if (cap == 0) return g;
      p = int'(shadow_head[c]);
      if (p >= PAGE_COUNT) begin
         for (p = 0; p < PAGE_COUNT; p++) if (!shadow_busy[p]) break;
         if (p >= PAGE_COUNT) begin
            g.status = RS_NO_PAGE;
            return g;
         end
         shadow_busy[p]  = 1'b1;
         shadow_cls[p]   = CLS_W'(c);
         shadow_used[p]  = 0;
         shadow_fresh[p] = 0;
         shadow_top[p]   = NO_SLOT;
         shadow_link[p]  = NO_PAGE;
         shadow_head[c]  = HEAD_W'(p);
      end
      if (shadow_top[p] != NO_SLOT && shadow_top[p] < SLOT_SPAN) begin
         slot = 32'(shadow_top[p]);
         shadow_top[p] = shadow_chain[p * SLOT_SPAN + slot];
      end else begin
         slot = shadow_fresh[p];
         shadow_fresh[p] = slot + 1;
         shadow_top[p] = NO_SLOT;
      end
      shadow_used[p]++;
      if (page_exhausted(p, cap)) shadow_head[c] = shadow_link[p];
      g.addr   = ADDR_W'(p * PAGE_BYTES + HEADER_BYTES + slot * class_bytes[c]);
      g.status = RS_OK;
      return g;
   endfunction

   function automatic grant_word_type grant_for_free(logic [ADDR_W-1:0] addr);
      grant_word_type g;
      int p, c;
      int unsigned off, rel, slot, cap;
      g = '{addr: '0, status: RS_BAD_FREE};
      p   = int'(addr) / PAGE_BYTES;
      off = 32'(addr) % PAGE_BYTES;
      if (p >= PAGE_COUNT || !shadow_busy[p]) return g;
      if (off < HEADER_BYTES) return g;
      c   = int'(shadow_cls[p]);
      cap = class_cap[c];
      rel = off - HEADER_BYTES;
      if (rel % class_bytes[c] != 0) return g;
      slot = rel / class_bytes[c];
      if (slot >= shadow_fresh[p] || slot >= cap) return g;
      if (page_exhausted(p, cap)) begin
         shadow_link[p] = shadow_head[c];
         shadow_head[c] = HEAD_W'(p);
      end
      shadow_chain[p * SLOT_SPAN + slot] = shadow_top[p];
      shadow_top[p] = TOP_W'(slot);
      if (shadow_used[p] > 0) shadow_used[p]--;
      g.status = RS_OK;
      if (shadow_used[p] == 0) sweep_classes();
      return g;
   endfunction

   // Offer one word, hold it until accepted, then log its expected grant.
   task automatic send_word(input logic kind, input logic [31:0] bytes,
                            input logic [ADDR_W-1:0] addr, output grant_word_type g);
      int gap;
      gap = gaps_off ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, addr, bytes};
      do @(posedge clock); while (!req_tready);
      g = (kind == KIND_ALLOC) ? grant_for_alloc(bytes) : grant_for_free(addr);
      expected_grants.push_back(g);
   endtask

   task automatic alloc_block(input logic [31:0] bytes);
      grant_word_type g;
      send_word(KIND_ALLOC, bytes, '0, g);
      if (g.status == RS_OK) live_blocks.push_back(g.addr);
   endtask

   task automatic free_block(input logic [ADDR_W-1:0] addr);
      grant_word_type g;
      send_word(KIND_FREE, '0, addr, g);
      if (g.status == RS_OK) begin
         freed_blocks.push_back(addr);
         if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
      end
   endtask

   // Free a randomly picked live block.
   task automatic free_live();
      int i;
      logic [ADDR_W-1:0] a;
      i = $urandom_range(0, live_blocks.size() - 1);
      a = live_blocks[i];
      live_blocks.delete(i);
      free_block(a);
   endtask

   // Size and address extremes, header and alignment faults, repeated free.
   task automatic test_edges();
      logic [ADDR_W-1:0] a;
      alloc_block(32'd0);
      alloc_block(32'd1);
      alloc_block(32'd5);
      alloc_block(32'd32768);
      alloc_block(32'd32769);
      alloc_block(32'hFFFF_FFFF);
      alloc_block(32'd26165);          // only the largest class holds it
      a = live_blocks[0];
      free_block(ADDR_W'(a - HEADER_BYTES + 1));  // offset inside the header
      free_block(ADDR_W'(a + 1));                 // off the slot boundary
      free_block(19'h7_0020);                     // page not in use
      free_block(ADDR_W'(a + 400));               // slot never handed out
      free_block(19'h7_FFFF);
      live_blocks.delete(0);
      free_block(a);
      free_block(a);                              // repeated free
      free_block(a);
   endtask

   // Fill the pool with two-slot pages until an allocate finds no page.
   task automatic test_pool_exhaust();
      repeat (18) alloc_block(32'd20000);
      while (live_blocks.size() > 0) free_live();
   endtask

   // Stall the result side for a long stretch while words keep coming.
   task automatic test_backpressure();
      gaps_off = 1'b1;
      rsp_hold_cycles = 300;
      repeat (24) alloc_block($urandom_range(1, 64));
      gaps_off = 1'b0;
      while (live_blocks.size() > 0) free_live();
   endtask

   task automatic test_random(input int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (n >= 200 && n < 260) gaps_off = 1'b1;   // burst with no idling
         else gaps_off = 1'b0;
         if (live_blocks.size() > 200) r = 60;
         if (r < 35) alloc_block($urandom_range(0, 300));
         else if (r < 45) alloc_block($urandom_range(300, 32768));
         else if (r < 50) alloc_block($urandom());
         else if (r < 85 && live_blocks.size() > 0) free_live();
         else if (r < 92 && freed_blocks.size() > 0)
            free_block(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
         else free_block(ADDR_W'($urandom()));
      end
      gaps_off = 1'b0;
   endtask

   // Result side: honor a requested hold-off, then random stalls per word.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            n = gaps_off ? 0 : $urandom_range(0, 14);
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare each accepted result word against the oldest expectation.
   always @(posedge clock) begin
      grant_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_grants.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word %h", rsp_tdata);
         end else begin
            want = expected_grants.pop_front();
            if (rsp_tdata[18:0] !== want.addr || rsp_tdata[20:19] !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                           want.addr, want.status, rsp_tdata[18:0], rsp_tdata[20:19]);
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edges();
      test_pool_exhaust();
      test_backpressure();
      test_random(400);
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (mismatch_count == 0 && expected_grants.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire
